// ===== src/hrtm_pkg.sv =====
// hrtm_pkg: widths, reset values, register codes and shared types of the
// hamming ratio-test matcher; used by every module under src
`default_nettype none

package hrtm_pkg;

	localparam int IDX_W      = 12;
	localparam int MAX_POINTS = 1 << IDX_W;
	localparam int DIST_W     = 9;
	localparam int WORD_W     = 64;
	localparam int DESC_W     = 4 * WORD_W;
	localparam int FRAC_W     = 8;
	localparam int EPOCH_W    = 10;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 3;

	localparam logic [DIST_W-1:0] DIST_NONE = DIST_W'(256);
	localparam logic [DIST_W-1:0] RATIO_RST = DIST_W'(192);
	localparam logic [DIST_W-1:0] MAXD_RST  = DIST_W'(50);

	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
	localparam logic [IDX_W-1:0]   IDX_LAST    = '1;

	typedef enum logic {
		REG_NN_RATIO = 1'b0,
		REG_MAX_DIST = 1'b1
	} reg_idx_t;

	typedef enum logic {
		CM_CLEAR = 1'b0,
		CM_RUN   = 1'b1
	} cm_state_t;

	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   idx;
		logic [EPOCH_W-1:0] epoch;
	} claim_wr_t;

	typedef struct packed {
		logic [DIST_W-1:0]  best;
		logic [DIST_W-1:0]  second;
		logic [IDX_W-1:0]   idx;
		logic [EPOCH_W-1:0] epoch;
	} res_t;

endpackage

`default_nettype wire

// ===== src/hamming_ratio_test_matcher.sv =====
// a request's result passes the input, distance and result stage registers to the output register
// throughput: one request per cycle while in_stall is low, set by the best/second update loop
// reset clears control state and runs a claim tag sweep over all 4096 tags with in_stall high;
// a new-search request that would wrap the 10-bit search epoch waits for an empty pipeline
// and the same sweep: at the 1023rd new search after reset, then every 1022nd
// top level: registers, input stage, distance stage, best tracking; uses hrtm_pkg,
// hrtm_popcount, hrtm_claim_map, hrtm_decide
`default_nettype none

module hamming_ratio_test_matcher (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [hrtm_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [hrtm_pkg::DATA_W-1:0]        pwdata,
	output logic      [hrtm_pkg::DATA_W-1:0]        prdata,
	output logic                                    pready,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               new_search,
	input  wire logic                               first_candidate,
	input  wire logic                               last_candidate,
	input  wire logic [hrtm_pkg::IDX_W-1:0]         candidate_index,
	input  wire logic [hrtm_pkg::WORD_W-1:0]        query_word0,
	input  wire logic [hrtm_pkg::WORD_W-1:0]        query_word1,
	input  wire logic [hrtm_pkg::WORD_W-1:0]        query_word2,
	input  wire logic [hrtm_pkg::WORD_W-1:0]        query_word3,
	input  wire logic [hrtm_pkg::WORD_W-1:0]        cand_word0,
	input  wire logic [hrtm_pkg::WORD_W-1:0]        cand_word1,
	input  wire logic [hrtm_pkg::WORD_W-1:0]        cand_word2,
	input  wire logic [hrtm_pkg::WORD_W-1:0]        cand_word3,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    match_found,
	output logic      [hrtm_pkg::IDX_W-1:0]         best_index,
	output logic      [hrtm_pkg::DIST_W-1:0]        best_distance,
	output logic      [hrtm_pkg::DIST_W-1:0]        second_distance
);

	localparam int PAD_W = hrtm_pkg::DATA_W - hrtm_pkg::DIST_W;

	// configuration registers
	logic [hrtm_pkg::DIST_W-1:0] ratio_q;
	logic [hrtm_pkg::DIST_W-1:0] max_dist_q;
	logic                        cfg_we;
	hrtm_pkg::reg_idx_t          cfg_sel;

	// input stage
	logic                          valid_s1;
	logic                          first_s1;
	logic                          last_s1;
	logic [hrtm_pkg::IDX_W-1:0]    idx_s1;
	logic [hrtm_pkg::DESC_W-1:0]   diff_s1;
	logic [hrtm_pkg::EPOCH_W-1:0]  epoch_s1;
	logic                          snoop_s1;

	// distance stage
	logic                          valid_s2;
	logic                          first_s2;
	logic                          last_s2;
	logic [hrtm_pkg::IDX_W-1:0]    idx_s2;
	logic [hrtm_pkg::EPOCH_W-1:0]  epoch_s2;
	logic [hrtm_pkg::DIST_W-1:0]   dist_s2;
	logic                          claimed_s2;

	// result stage
	logic                          valid_s3;
	hrtm_pkg::res_t                res_s3;

	// running best state
	logic [hrtm_pkg::DIST_W-1:0]   best_q;
	logic [hrtm_pkg::DIST_W-1:0]   second_q;
	logic [hrtm_pkg::IDX_W-1:0]    best_idx_q;

	logic                          accept;
	logic                          ready1;
	logic                          ready2;
	logic                          ready3;
	logic                          fire2;
	logic                          s3_free;
	logic                          pipe_empty;
	logic                          cm_stall;
	logic [hrtm_pkg::EPOCH_W-1:0]  ep_in;
	logic [hrtm_pkg::EPOCH_W-1:0]  rd_tag;
	logic [hrtm_pkg::DIST_W-1:0]   dist_s1;
	hrtm_pkg::claim_wr_t           claim_wr;

	logic                          hit_in;
	logic                          hit1;
	logic                          hit2;
	logic                          claimed_now;
	logic [hrtm_pkg::DIST_W-1:0]   base_best;
	logic [hrtm_pkg::DIST_W-1:0]   base_second;
	logic [hrtm_pkg::IDX_W-1:0]    base_idx;
	logic [hrtm_pkg::DIST_W-1:0]   nxt_best;
	logic [hrtm_pkg::DIST_W-1:0]   nxt_second;
	logic [hrtm_pkg::IDX_W-1:0]    nxt_idx;

	function automatic logic claim_hit(
		input hrtm_pkg::claim_wr_t          w,
		input logic [hrtm_pkg::IDX_W-1:0]   idx,
		input logic [hrtm_pkg::EPOCH_W-1:0] ep
	);
		return w.en && (w.idx == idx) && (w.epoch == ep);
	endfunction

	// configuration port
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_sel = hrtm_pkg::reg_idx_t'(paddr[2]);

	always_comb begin
		case (cfg_sel)
			hrtm_pkg::REG_NN_RATIO: prdata = {{PAD_W{1'b0}}, ratio_q};
			hrtm_pkg::REG_MAX_DIST: prdata = {{PAD_W{1'b0}}, max_dist_q};
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q    <= hrtm_pkg::RATIO_RST;
			max_dist_q <= hrtm_pkg::MAXD_RST;
		end else if (cfg_we) begin
			case (cfg_sel)
				hrtm_pkg::REG_NN_RATIO: ratio_q    <= pwdata[hrtm_pkg::DIST_W-1:0];
				hrtm_pkg::REG_MAX_DIST: max_dist_q <= pwdata[hrtm_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control
	assign s3_free    = !valid_s3 || ready3;
	assign ready2     = s3_free;
	assign ready1     = !valid_s2 || ready2;
	assign fire2      = valid_s2 && ready2;
	assign in_stall   = cm_stall || (valid_s1 && !ready1);
	assign accept     = in_valid && !in_stall;
	assign pipe_empty = !valid_s1 && !valid_s2 && !valid_s3;

	// claims written by results ahead of a request
	assign hit_in = claim_hit(claim_wr, candidate_index, ep_in);
	assign hit1   = claim_hit(claim_wr, idx_s1, epoch_s1);
	assign hit2   = claim_hit(claim_wr, idx_s2, epoch_s2);

	hrtm_claim_map u_claim_map (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (in_valid),
		.req_new_search (new_search),
		.rd_en          (accept),
		.rd_addr        (candidate_index),
		.pipe_empty     (pipe_empty),
		.wr             (claim_wr),
		.stall          (cm_stall),
		.ep_in          (ep_in),
		.rd_tag         (rd_tag)
	);

	hrtm_popcount u_popcount (
		.bits  (diff_s1),
		.count (dist_s1)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || ready1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1 <= first_candidate;
			last_s1  <= last_candidate;
			idx_s1   <= candidate_index;
			epoch_s1 <= ep_in;
			snoop_s1 <= hit_in;
			diff_s1  <= {query_word3 ^ cand_word3, query_word2 ^ cand_word2,
				query_word1 ^ cand_word1, query_word0 ^ cand_word0};
		end else if (valid_s1 && !ready1) begin
			snoop_s1 <= snoop_s1 || hit1;
		end
	end

	// distance stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready1 && valid_s1) begin
			first_s2   <= first_s1;
			last_s2    <= last_s1;
			idx_s2     <= idx_s1;
			epoch_s2   <= epoch_s1;
			dist_s2    <= dist_s1;
			claimed_s2 <= (rd_tag == epoch_s1) || snoop_s1 || hit1;
		end else if (valid_s2 && !ready2) begin
			claimed_s2 <= claimed_s2 || hit2;
		end
	end

	// best and second-best update
	always_comb begin
		base_best   = first_s2 ? hrtm_pkg::DIST_NONE : best_q;
		base_second = first_s2 ? hrtm_pkg::DIST_NONE : second_q;
		base_idx    = first_s2 ? '0 : best_idx_q;
		claimed_now = claimed_s2 || hit2;
		nxt_best    = base_best;
		nxt_second  = base_second;
		nxt_idx     = base_idx;
		if (!claimed_now) begin
			if (dist_s2 < base_best) begin
				nxt_second = base_best;
				nxt_best   = dist_s2;
				nxt_idx    = idx_s2;
			end else if (dist_s2 < base_second) begin
				nxt_second = dist_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= hrtm_pkg::DIST_NONE;
			second_q   <= hrtm_pkg::DIST_NONE;
			best_idx_q <= '0;
		end else if (fire2) begin
			best_q     <= nxt_best;
			second_q   <= nxt_second;
			best_idx_q <= nxt_idx;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && valid_s2 && last_s2) begin
			res_s3.best   <= nxt_best;
			res_s3.second <= nxt_second;
			res_s3.idx    <= nxt_idx;
			res_s3.epoch  <= epoch_s2;
		end
	end

	hrtm_decide u_decide (
		.clk             (clk),
		.arst_n          (arst_n),
		.s3_valid        (valid_s3),
		.s3              (res_s3),
		.ratio           (ratio_q),
		.max_dist        (max_dist_q),
		.out_stall       (out_stall),
		.ready           (ready3),
		.wr              (claim_wr),
		.out_valid       (out_valid),
		.match_found     (match_found),
		.best_index      (best_index),
		.best_distance   (best_distance),
		.second_distance (second_distance)
	);

endmodule

`default_nettype wire

// ===== src/hrtm_popcount.sv =====
// hrtm_popcount: adder-tree population count of the 256-bit descriptor xor
// depends on hrtm_pkg
`default_nettype none

module hrtm_popcount (
	input  wire logic [hrtm_pkg::DESC_W-1:0] bits,
	output logic      [hrtm_pkg::DIST_W-1:0] count
);

	logic [3:0] c8   [32];
	logic [4:0] c16  [16];
	logic [5:0] c32  [8];
	logic [6:0] c64  [4];
	logic [7:0] c128 [2];

	function automatic logic [3:0] pop8(input logic [7:0] b);
		logic [3:0] s;
		s = '0;
		for (int k = 0; k < 8; k++) begin
			s = s + {3'b000, b[k]};
		end
		return s;
	endfunction

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			c8[i] = pop8(bits[8*i +: 8]);
		end
		for (int i = 0; i < 16; i++) begin
			c16[i] = {1'b0, c8[2*i]} + {1'b0, c8[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			c32[i] = {1'b0, c16[2*i]} + {1'b0, c16[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			c64[i] = {1'b0, c32[2*i]} + {1'b0, c32[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			c128[i] = {1'b0, c64[2*i]} + {1'b0, c64[2*i+1]};
		end
		count = {1'b0, c128[0]} + {1'b0, c128[1]};
	end

endmodule

`default_nettype wire

// ===== src/hrtm_claim_map.sv =====
// hrtm_claim_map: per-candidate claim tags with a search epoch, tag memory,
// and the clearing sweep after reset and on epoch wrap; depends on hrtm_pkg
`default_nettype none

module hrtm_claim_map (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	input  wire logic                            req_new_search,
	input  wire logic                            rd_en,
	input  wire logic [hrtm_pkg::IDX_W-1:0]      rd_addr,
	input  wire logic                            pipe_empty,
	input  wire hrtm_pkg::claim_wr_t             wr,
	output logic                                 stall,
	output logic      [hrtm_pkg::EPOCH_W-1:0]    ep_in,
	output logic      [hrtm_pkg::EPOCH_W-1:0]    rd_tag
);

	hrtm_pkg::cm_state_t state_q, state_d;
	logic [hrtm_pkg::IDX_W-1:0]   sweep_addr_q;
	logic [hrtm_pkg::EPOCH_W-1:0] epoch_q;
	logic [hrtm_pkg::EPOCH_W-1:0] rd_tag_q;
	logic [hrtm_pkg::EPOCH_W-1:0] tag_mem [hrtm_pkg::MAX_POINTS];
	logic                         sweep_we;
	logic                         wrap_hold;

	assign wrap_hold = req_valid && req_new_search && (epoch_q == hrtm_pkg::EPOCH_MAX);
	assign ep_in     = req_new_search ? epoch_q + hrtm_pkg::EPOCH_W'(1) : epoch_q;
	assign rd_tag    = rd_tag_q;

	always_comb begin
		state_d  = state_q;
		stall    = 1'b0;
		sweep_we = 1'b0;
		case (state_q)
			hrtm_pkg::CM_CLEAR: begin
				stall    = 1'b1;
				sweep_we = 1'b1;
				if (sweep_addr_q == hrtm_pkg::IDX_LAST) begin
					state_d = hrtm_pkg::CM_RUN;
				end
			end
			hrtm_pkg::CM_RUN: begin
				if (wrap_hold) begin
					stall = 1'b1;
					if (pipe_empty) begin
						state_d = hrtm_pkg::CM_CLEAR;
					end
				end
			end
			default: begin
				state_d = hrtm_pkg::CM_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hrtm_pkg::CM_CLEAR;
			sweep_addr_q <= '0;
			epoch_q      <= hrtm_pkg::EPOCH_FIRST;
		end else begin
			state_q <= state_d;
			if (sweep_we) begin
				sweep_addr_q <= sweep_addr_q + hrtm_pkg::IDX_W'(1);
			end
			if (state_q == hrtm_pkg::CM_CLEAR && state_d == hrtm_pkg::CM_RUN) begin
				epoch_q <= hrtm_pkg::EPOCH_FIRST;
			end else if (rd_en && req_new_search) begin
				epoch_q <= ep_in;
			end
		end
	end

	// tag memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (sweep_we) begin
			tag_mem[sweep_addr_q] <= '0;
		end else if (wr.en) begin
			tag_mem[wr.idx] <= wr.epoch;
		end
		if (rd_en) begin
			rd_tag_q <= tag_mem[rd_addr];
		end
	end

	a_no_claim_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> state_q == hrtm_pkg::CM_RUN)
		else $error("claim write during clearing sweep");

	a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> state_q == hrtm_pkg::CM_RUN)
		else $error("request taken during clearing sweep");

endmodule

`default_nettype wire

// ===== src/hrtm_decide.sv =====
// hrtm_decide: threshold and ratio test on a finished query, result register
// and claim write; depends on hrtm_pkg
`default_nettype none

module hrtm_decide (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s3_valid,
	input  wire hrtm_pkg::res_t               s3,
	input  wire logic [hrtm_pkg::DIST_W-1:0]  ratio,
	input  wire logic [hrtm_pkg::DIST_W-1:0]  max_dist,
	input  wire logic                         out_stall,
	output logic                              ready,
	output hrtm_pkg::claim_wr_t               wr,
	output logic                              out_valid,
	output logic                              match_found,
	output logic      [hrtm_pkg::IDX_W-1:0]   best_index,
	output logic      [hrtm_pkg::DIST_W-1:0]  best_distance,
	output logic      [hrtm_pkg::DIST_W-1:0]  second_distance
);

	localparam int PROD_W = 2 * hrtm_pkg::DIST_W;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] scaled;
	logic              match;
	logic              fire;

	assign prod   = PROD_W'(ratio) * PROD_W'(s3.second);
	assign scaled = {{(PROD_W - hrtm_pkg::DIST_W - hrtm_pkg::FRAC_W){1'b0}}, s3.best,
		{hrtm_pkg::FRAC_W{1'b0}}};
	assign match  = (s3.best < hrtm_pkg::DIST_NONE) && (s3.best <= max_dist)
		&& (scaled < prod);

	assign ready = !out_valid || !out_stall;
	assign fire  = s3_valid && ready;

	assign wr = {fire && match, s3.idx, s3.epoch};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready) begin
			out_valid <= s3_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			match_found     <= match;
			best_index      <= match ? s3.idx : '0;
			best_distance   <= s3.best;
			second_distance <= s3.second;
		end
	end

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_distance <= second_distance)
		else $error("best distance above second distance");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !match_found) |-> best_index == '0)
		else $error("index shown on a result without match");

	a_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && match_found) |-> (best_distance <= max_dist
		&& best_distance != hrtm_pkg::DIST_NONE))
		else $error("match beyond distance threshold");

endmodule

`default_nettype wire

// ===== sim/hamming_ratio_test_matcher_tb.sv =====
// testbench for hamming_ratio_test_matcher: streams candidate requests, predicts each match
// decision in a local scoreboard and checks every result; needs hrtm_pkg and the matcher rtl
`timescale 1ns / 1ps

module hamming_ratio_test_matcher_tb;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int HOLD_CYCLES = 400;
	localparam int BURST_MAX   = 16;
	localparam int DESC_W      = hrtm_pkg::DESC_W;

	typedef struct packed {
		logic                       fresh;
		logic                       first;
		logic                       last;
		logic [hrtm_pkg::IDX_W-1:0] idx;
		logic [DESC_W-1:0]          query;
		logic [DESC_W-1:0]          cand;
	} cand_req_t;

	typedef struct packed {
		logic                        match;
		logic [hrtm_pkg::IDX_W-1:0]  idx;
		logic [hrtm_pkg::DIST_W-1:0] best;
		logic [hrtm_pkg::DIST_W-1:0] second;
	} decision_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite;
	logic [hrtm_pkg::ADDR_W-1:0] paddr;
	logic [hrtm_pkg::DATA_W-1:0] pwdata;
	logic [hrtm_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid, in_stall;
	logic new_search, first_candidate, last_candidate;
	logic [hrtm_pkg::IDX_W-1:0] candidate_index;
	logic [hrtm_pkg::WORD_W-1:0] query_word0, query_word1, query_word2, query_word3;
	logic [hrtm_pkg::WORD_W-1:0] cand_word0, cand_word1, cand_word2, cand_word3;
	logic out_valid;
	logic out_stall = 1'b0;
	logic match_found;
	logic [hrtm_pkg::IDX_W-1:0] best_index;
	logic [hrtm_pkg::DIST_W-1:0] best_distance, second_distance;

	// scoreboard state
	logic [hrtm_pkg::MAX_POINTS-1:0] claimed_set = '0;
	int unsigned nn_best = 256;
	int unsigned nn_second = 256;
	logic [hrtm_pkg::IDX_W-1:0] nn_best_idx = '0;
	int unsigned ratio_q8 = hrtm_pkg::RATIO_RST;
	int unsigned max_dist = hrtm_pkg::MAXD_RST;
	decision_t pending_decisions[$];

	int errors = 0;
	int requests_sent = 0;
	int searches = 0;
	int decisions_checked = 0;
	int matches_predicted = 0;
	int reg_writes = 0;
	int cycles = 0;

	int gap_max = 0;
	int stall_pct = 0;
	int burst_left = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	hamming_ratio_test_matcher DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.new_search(new_search),
		.first_candidate(first_candidate),
		.last_candidate(last_candidate),
		.candidate_index(candidate_index),
		.query_word0(query_word0),
		.query_word1(query_word1),
		.query_word2(query_word2),
		.query_word3(query_word3),
		.cand_word0(cand_word0),
		.cand_word1(cand_word1),
		.cand_word2(cand_word2),
		.cand_word3(cand_word3),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.match_found(match_found),
		.best_index(best_index),
		.best_distance(best_distance),
		.second_distance(second_distance)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_decisions.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic void log_fault(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	// match decision for one accepted request
	function automatic void score_candidate(cand_req_t r);
		int unsigned d;
		logic hit;
		decision_t res;
		if (r.fresh) begin
			claimed_set = '0;
			searches++;
		end
		if (r.first) begin
			nn_best = 256;
			nn_second = 256;
			nn_best_idx = '0;
		end
		if (!claimed_set[r.idx]) begin
			d = $countones(r.query ^ r.cand);
			if (d < nn_best) begin
				nn_second = nn_best;
				nn_best = d;
				nn_best_idx = r.idx;
			end else if (d < nn_second) begin
				nn_second = d;
			end
		end
		if (r.last) begin
			hit = nn_best < 256 && nn_best <= max_dist && nn_best * 256 < ratio_q8 * nn_second;
			if (hit) begin
				claimed_set[nn_best_idx] = 1'b1;
				matches_predicted++;
			end
			res.match = hit;
			res.idx = hit ? nn_best_idx : '0;
			res.best = hrtm_pkg::DIST_W'(nn_best);
			res.second = hrtm_pkg::DIST_W'(nn_second);
			pending_decisions.insert(pending_decisions.size(), res);
		end
	endfunction

	function automatic cand_req_t make_req(logic fresh, logic first, logic last,
			logic [hrtm_pkg::IDX_W-1:0] idx, logic [DESC_W-1:0] query, logic [DESC_W-1:0] cand);
		cand_req_t r;
		r.fresh = fresh;
		r.first = first;
		r.last = last;
		r.idx = idx;
		r.query = query;
		r.cand = cand;
		return r;
	endfunction

	function automatic logic [DESC_W-1:0] rand_desc();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic logic [DESC_W-1:0] flip_bits(logic [DESC_W-1:0] d, int n);
		logic [7:0] pos;
		for (int k = 0; k < n; k++) begin
			pos = 8'($urandom_range(DESC_W - 1));
			d[pos] = ~d[pos];
		end
		return d;
	endfunction

	// exactly n bits apart
	function automatic logic [DESC_W-1:0] at_distance(logic [DESC_W-1:0] d, int n);
		logic [DESC_W-1:0] mask;
		mask = (n >= DESC_W) ? '1 : ~({DESC_W{1'b1}} << n);
		return d ^ mask;
	endfunction

	task automatic set_pacing(input int gap, input int stall);
		gap_max = gap;
		stall_pct = stall;
		burst_left = 0;
	endtask

	task automatic push_request(input cand_req_t r);
		int gap;
		in_valid <= 1'b1;
		new_search <= r.fresh;
		first_candidate <= r.first;
		last_candidate <= r.last;
		candidate_index <= r.idx;
		query_word0 <= r.query[63:0];
		query_word1 <= r.query[127:64];
		query_word2 <= r.query[191:128];
		query_word3 <= r.query[255:192];
		cand_word0 <= r.cand[63:0];
		cand_word1 <= r.cand[127:64];
		cand_word2 <= r.cand[191:128];
		cand_word3 <= r.cand[255:192];
		do @(posedge clk); while (in_stall);
		score_candidate(r);
		requests_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(BURST_MAX, 1);
			gap = $urandom_range(gap_max, 0);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic check_reg(input hrtm_pkg::reg_idx_t which, input logic [8:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {which, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[8:0] !== want)
			log_fault($sformatf("register %s readback: expected %0d, got %0d", which.name(),
				want, prdata[8:0]));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input hrtm_pkg::reg_idx_t which, input logic [8:0] value);
		logic [hrtm_pkg::DATA_W-1:0] word;
		word = $urandom;
		word[8:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (which == hrtm_pkg::REG_NN_RATIO)
			ratio_q8 = 32'(value);
		else
			max_dist = 32'(value);
		reg_writes++;
		@(posedge clk);
		check_reg(which, value);
	endtask

	task automatic configure(input logic [8:0] ratio, input logic [8:0] maxd);
		settle();
		write_reg(hrtm_pkg::REG_NN_RATIO, ratio);
		write_reg(hrtm_pkg::REG_MAX_DIST, maxd);
	endtask

	// random searches: well-formed queries with a little noise on the flags
	task automatic run_searches(input int n_items, input int idx_span);
		int unsigned n_queries, n_cands, roll;
		int stop_at;
		logic [DESC_W-1:0] q, c;
		cand_req_t r;
		stop_at = requests_sent + n_items;
		while (requests_sent < stop_at) begin
			n_queries = $urandom_range(4, 1);
			for (int qi = 0; qi < n_queries; qi++) begin
				roll = $urandom_range(99);
				if (roll < 4)
					q = '0;
				else if (roll < 8)
					q = '1;
				else
					q = rand_desc();
				n_cands = $urandom_range(6, 1);
				for (int ci = 0; ci < n_cands; ci++) begin
					roll = $urandom_range(99);
					if (roll < 50)
						c = flip_bits(q, $urandom_range(30));
					else if (roll < 70)
						c = flip_bits(q, $urandom_range(4));
					else if (roll < 80)
						c = flip_bits(~q, $urandom_range(3));
					else if (roll < 88)
						c = q;
					else
						c = rand_desc();
					r = make_req(qi == 0 && ci == 0, ci == 0, ci == n_cands - 1,
						hrtm_pkg::IDX_W'($urandom_range(idx_span)), q, c);
					roll = $urandom_range(99);
					if (roll < 6)
						r.first = ~r.first;
					else if (roll < 11)
						r.last = ~r.last;
					else if (roll < 14)
						r.fresh = 1'b1;
					push_request(r);
				end
			end
		end
	endtask

	task automatic test_reset_values();
		check_reg(hrtm_pkg::REG_NN_RATIO, hrtm_pkg::RATIO_RST);
		check_reg(hrtm_pkg::REG_MAX_DIST, hrtm_pkg::MAXD_RST);
	endtask

	task automatic test_directed();
		logic [DESC_W-1:0] q;
		q = rand_desc();
		set_pacing(2, 20);
		// exact hit, then the claimed index is skipped
		push_request(make_req(1, 1, 1, 0, q, q));
		push_request(make_req(0, 1, 0, 0, q, q));
		// full-distance candidate leaves both distances at none
		push_request(make_req(0, 0, 1, 4095, q, ~q));
		// no first flag: distances carry over, tie on best
		push_request(make_req(0, 0, 0, 5, q, at_distance(q, 10)));
		push_request(make_req(0, 0, 1, 6, q, at_distance(~q, 246)));
		push_request(make_req(0, 0, 1, 7, q, at_distance(q, 3)));
		push_request(make_req(0, 1, 1, 7, q, q));
		// new search clears claims
		push_request(make_req(1, 1, 1, 7, q, q));
		push_request(make_req(1, 1, 0, 4095, '0, '1));
		push_request(make_req(0, 0, 1, 4094, '1, '1));
		// threshold edge
		push_request(make_req(0, 1, 1, 100, q, at_distance(q, 50)));
		push_request(make_req(0, 1, 1, 101, q, at_distance(q, 51)));
		// ratio edge, larger distance arrives first
		push_request(make_req(0, 1, 0, 200, q, at_distance(q, 40)));
		push_request(make_req(0, 0, 1, 201, q, at_distance(q, 30)));
		push_request(make_req(0, 1, 0, 202, q, at_distance(q, 40)));
		push_request(make_req(0, 0, 1, 203, q, at_distance(q, 29)));
		// equal to second does not replace it
		push_request(make_req(0, 1, 0, 300, q, at_distance(q, 5)));
		push_request(make_req(0, 0, 0, 301, q, at_distance(q, 9)));
		push_request(make_req(0, 0, 1, 302, q, at_distance(q, 9)));
	endtask

	task automatic test_register_extremes();
		logic [DESC_W-1:0] q;
		q = rand_desc();
		configure(9'd511, 9'd511);
		push_request(make_req(1, 1, 1, 3, q, ~q));
		push_request(make_req(0, 1, 1, 4, q, at_distance(q, 255)));
		configure(9'd0, 9'd0);
		push_request(make_req(0, 1, 1, 9, q, q));
		configure(9'd256, 9'd0);
		push_request(make_req(0, 1, 1, 10, q, q));
		push_request(make_req(0, 1, 1, 11, q, at_distance(q, 1)));
		configure(9'd256, 9'd256);
		push_request(make_req(0, 1, 0, 12, q, at_distance(q, 8)));
		push_request(make_req(0, 0, 1, 13, q, at_distance(q, 8)));
	endtask

	task automatic test_random_searches();
		configure(hrtm_pkg::RATIO_RST, hrtm_pkg::MAXD_RST);
		set_pacing(4, 30);
		run_searches(60, 31);
		configure(9'd256, 9'd256);
		set_pacing(0, 0);
		run_searches(40, 15);
		configure(9'd0, 9'd0);
		set_pacing(2, 50);
		run_searches(30, 4095);
		configure(9'd511, 9'd511);
		set_pacing(6, 60);
		run_searches(40, 63);
		configure(9'($urandom_range(511)), 9'($urandom_range(511)));
		set_pacing(3, 20);
		run_searches(80, 4095);
	endtask

	function automatic logic [DESC_W-1:0] q_pick();
		return flip_bits('0, $urandom_range(8));
	endfunction

	// receiver holds off while every request makes a result
	task automatic test_backpressure_fill();
		configure(hrtm_pkg::RATIO_RST, hrtm_pkg::MAXD_RST);
		set_pacing(0, 0);
		hold_seq++;
		for (int n = 0; n < 64; n++)
			push_request(make_req(n == 0, 1, 1, hrtm_pkg::IDX_W'(n), q_pick(), '0));
	endtask

	// short searches that reuse a few indexes across new searches
	task automatic test_search_restart();
		logic [DESC_W-1:0] q;
		logic [hrtm_pkg::IDX_W-1:0] a;
		configure(9'd224, 9'd64);
		set_pacing(1, 10);
		for (int s = 0; s < 25; s++) begin
			q = rand_desc();
			a = hrtm_pkg::IDX_W'($urandom_range(15));
			push_request(make_req(1, 1, 0, a, q, flip_bits(q, $urandom_range(12))));
			push_request(make_req(0, 0, 1, hrtm_pkg::IDX_W'($urandom_range(15)), q,
				rand_desc()));
			push_request(make_req(0, 1, 1, a, q, flip_bits(q, $urandom_range(12))));
		end
	endtask

	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		decision_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_decisions.size() == 0) begin
				log_fault($sformatf("unexpected result: match %0d index %0d best %0d second %0d",
					match_found, best_index, best_distance, second_distance));
			end else begin
				want = pending_decisions.pop_front();
				if (match_found !== want.match)
					log_fault($sformatf("result %0d match_found: expected %0d, got %0d",
						decisions_checked, want.match, match_found));
				if (best_index !== want.idx)
					log_fault($sformatf("result %0d best_index: expected %0d, got %0d",
						decisions_checked, want.idx, best_index));
				if (best_distance !== want.best)
					log_fault($sformatf("result %0d best_distance: expected %0d, got %0d",
						decisions_checked, want.best, best_distance));
				if (second_distance !== want.second)
					log_fault($sformatf("result %0d second_distance: expected %0d, got %0d",
						decisions_checked, want.second, second_distance));
			end
			decisions_checked++;
		end
	end

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		new_search = 1'b0;
		first_candidate = 1'b0;
		last_candidate = 1'b0;
		candidate_index = '0;
		query_word0 = '0;
		query_word1 = '0;
		query_word2 = '0;
		query_word3 = '0;
		cand_word0 = '0;
		cand_word1 = '0;
		cand_word2 = '0;
		cand_word3 = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed();
		test_register_extremes();
		test_random_searches();
		test_backpressure_fill();
		test_search_restart();
		settle();

		$display("%0d requests over %0d searches, %0d results checked, %0d matches",
			requests_sent, searches, decisions_checked, matches_predicted);
		$display("%0d register writes, %0d faults, %0d cycles", reg_writes, errors, cycles);
		if (errors == 0 && pending_decisions.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== hamming_ratio_test_matcher.f =====
src/hrtm_pkg.sv
src/hrtm_popcount.sv
src/hrtm_claim_map.sv
src/hrtm_decide.sv
src/hamming_ratio_test_matcher.sv
sim/hamming_ratio_test_matcher_tb.sv
